### src/spc_pkg.sv
// shared types and constants of the stepper position controller
package spc_pkg;

  localparam int unsigned PosW       = 25;
  localparam int unsigned StepW      = PosW + 1;
  localparam int unsigned MaxW       = 24;
  localparam int unsigned OpW        = 3;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [MaxW-1:0] MaxReset = {MaxW{1'b1}};

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 3'd0,
    OP_MOVE_REL  = 3'd1,
    OP_MOVE_ABS  = 3'd2,
    OP_HOME_LOW  = 3'd3,
    OP_HOME_HIGH = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_REL,
    KIND_ABS,
    KIND_HOME_LOW,
    KIND_HOME_HIGH,
    KIND_NOP
  } kind_e;

  typedef enum logic [1:0] {
    STOP_OK      = 2'd0,
    STOP_ENDSTOP = 2'd1,
    STOP_CANCEL  = 2'd2
  } stop_e;

  typedef struct packed {
    kind_e            kind;
    logic [PosW-1:0]  distance;
    logic             limits;
    logic             endstop;
    logic             cancel;
  } cmd_t;

  typedef struct packed {
    stop_e            stop;
    logic             busy;
    logic [PosW-1:0]  position;
    logic             coil_b;
    logic             coil_a;
  } result_t;

endpackage

### src/spc_front.sv
// front stage: takes requests and classifies them into commands
module spc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [spc_pkg::OpW-1:0]     in_op_i,
  input  logic [spc_pkg::PosW-1:0]    in_dist_i,
  input  logic                        in_limits_i,
  input  logic                        in_endstop_i,
  input  logic                        in_cancel_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output spc_pkg::cmd_t               cmd_o
);

  logic          valid_q, valid_d;
  spc_pkg::cmd_t cmd_q, cmd_d;
  spc_pkg::kind_e kind;

  always_comb begin
    case (spc_pkg::op_e'(in_op_i))
      spc_pkg::OP_TICK:      kind = spc_pkg::KIND_TICK;
      spc_pkg::OP_MOVE_REL:  kind = spc_pkg::KIND_REL;
      spc_pkg::OP_MOVE_ABS:  kind = spc_pkg::KIND_ABS;
      spc_pkg::OP_HOME_LOW:  kind = spc_pkg::KIND_HOME_LOW;
      spc_pkg::OP_HOME_HIGH: kind = spc_pkg::KIND_HOME_HIGH;
      default:               kind = spc_pkg::KIND_NOP;
    endcase
  end

  assign in_ready_o = !valid_q || cmd_ready_i;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
    if (in_ready_o && in_valid_i) begin
      cmd_d.kind     = kind;
      cmd_d.distance = in_dist_i;
      cmd_d.limits   = in_limits_i;
      cmd_d.endstop  = in_endstop_i;
      cmd_d.cancel   = in_cancel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

### src/spc_queue.sv
// short command queue between front and back
module spc_queue #(
  parameter int unsigned Depth = spc_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  spc_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output spc_pkg::cmd_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  spc_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign wr_ready_o = cnt_q != FullCnt;
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### src/spc_back.sv
// back stage: motion state, step execution and result register
module spc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [spc_pkg::MaxW-1:0]  max_pos_i,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  spc_pkg::cmd_t             cmd_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output spc_pkg::result_t          res_o
);

  localparam int unsigned PosW  = spc_pkg::PosW;
  localparam int unsigned StepW = spc_pkg::StepW;

  typedef enum logic [1:0] {
    HOME_NONE = 2'd0,
    HOME_LOW  = 2'd1,
    HOME_HIGH = 2'd2
  } home_e;

  logic [PosW-1:0]    pos_q, pos_d;
  logic [StepW-1:0]   steps_q, steps_d;
  logic [1:0]         phase_q, phase_d;
  spc_pkg::stop_e     stop_q, stop_d;
  home_e              home_q, home_d;
  logic               res_valid_q, res_valid_d;
  spc_pkg::result_t   res_q, res_d;

  logic [StepW-1:0]   pos_ext, dist_ext, max_ext, base, target, move_steps, step_next;
  logic               fire;

  assign cmd_ready_o = !res_valid_q || res_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    pos_ext  = {pos_q[PosW-1], pos_q};
    dist_ext = {cmd_i.distance[PosW-1], cmd_i.distance};
    max_ext  = StepW'(max_pos_i);
    base     = (cmd_i.kind == spc_pkg::KIND_REL) ? pos_ext + dist_ext : dist_ext;
    target   = base;
    if (cmd_i.limits) begin
      if ($signed(base) > $signed(max_ext)) begin
        target = max_ext;
      end else if (base[StepW-1]) begin
        target = '0;
      end
    end
    move_steps = target - pos_ext;
    step_next  = steps_q[StepW-1] ? steps_q + StepW'(1) : steps_q - StepW'(1);

    pos_d   = pos_q;
    steps_d = steps_q;
    phase_d = phase_q;
    stop_d  = stop_q;
    home_d  = home_q;

    case (cmd_i.kind)
      spc_pkg::KIND_TICK: begin
        if (steps_q != '0) begin
          if (cmd_i.endstop) begin
            stop_d  = spc_pkg::STOP_ENDSTOP;
            steps_d = '0;
            home_d  = HOME_NONE;
            if (home_q == HOME_LOW) begin
              pos_d = '0;
            end else if (home_q == HOME_HIGH) begin
              pos_d = PosW'(max_pos_i);
            end
          end else if (cmd_i.cancel) begin
            stop_d  = spc_pkg::STOP_CANCEL;
            steps_d = '0;
            home_d  = HOME_NONE;
          end else begin
            steps_d = step_next;
            if (!steps_q[StepW-1]) begin
              phase_d = phase_q + 2'd1;
              pos_d   = pos_q + PosW'(1);
            end else begin
              phase_d = phase_q - 2'd1;
              pos_d   = pos_q - PosW'(1);
            end
            if (step_next == '0) begin
              home_d = HOME_NONE;
            end
          end
        end
      end
      spc_pkg::KIND_REL, spc_pkg::KIND_ABS: begin
        steps_d = move_steps;
        stop_d  = spc_pkg::STOP_OK;
        home_d  = HOME_NONE;
      end
      spc_pkg::KIND_HOME_LOW: begin
        steps_d = StepW'(0) - max_ext;
        stop_d  = spc_pkg::STOP_OK;
        home_d  = (max_pos_i != '0) ? HOME_LOW : HOME_NONE;
      end
      spc_pkg::KIND_HOME_HIGH: begin
        steps_d = max_ext;
        stop_d  = spc_pkg::STOP_OK;
        home_d  = (max_pos_i != '0) ? HOME_HIGH : HOME_NONE;
      end
      default: begin
      end
    endcase

    res_d.coil_a   = phase_d[1] ^ phase_d[0];
    res_d.coil_b   = phase_d[1];
    res_d.position = pos_d;
    res_d.busy     = steps_d != '0;
    res_d.stop     = stop_d;

    res_valid_d = res_valid_q;
    if (cmd_ready_o) begin
      res_valid_d = cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      steps_q     <= '0;
      phase_q     <= '0;
      stop_q      <= spc_pkg::STOP_OK;
      home_q      <= HOME_NONE;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (fire) begin
        pos_q   <= pos_d;
        steps_q <= steps_d;
        phase_q <= phase_d;
        stop_q  <= stop_d;
        home_q  <= home_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### src/stepper_position_controller.sv
// full-step bipolar stepper position controller, top level
// path: a request passes the front register and the queue; its result is registered in the back stage
// throughput: one request per cycle unless results stall, set by the step update in the back stage
// the command queue lets requests keep flowing for its depth while results are stalled
// reset: asynchronous active low; position, remaining steps, phase and flags clear,
// max_position returns to 16777215
module stepper_position_controller #(
  parameter int unsigned QueueDepth = spc_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spc_pkg::MaxW-1:0]      cfg_wdata_i,     // max_position
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [spc_pkg::InDataW-1:0]   s_axis_tdata,    // distance, use_limits, endstop, cancel
  input  logic [spc_pkg::OpW-1:0]       s_axis_tuser,    // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [spc_pkg::OutDataW-1:0]  m_axis_tdata     // coil_a, coil_b, position, busy_res, stop_flag
);

  localparam int unsigned PosW = spc_pkg::PosW;
  localparam int unsigned ResW = $bits(spc_pkg::result_t);

  logic [spc_pkg::MaxW-1:0] max_pos_q;
  logic                     fq_valid, fq_ready, qb_valid, qb_ready;
  spc_pkg::cmd_t            fq_cmd, qb_cmd;
  spc_pkg::result_t         res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pos_q <= spc_pkg::MaxReset;
    end else if (cfg_we_i) begin
      max_pos_q <= cfg_wdata_i;
    end
  end

  spc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_dist_i    (s_axis_tdata[PosW-1:0]),
    .in_limits_i  (s_axis_tdata[PosW]),
    .in_endstop_i (s_axis_tdata[PosW+1]),
    .in_cancel_i  (s_axis_tdata[PosW+2]),
    .cmd_valid_o  (fq_valid),
    .cmd_ready_i  (fq_ready),
    .cmd_o        (fq_cmd)
  );

  spc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_cmd),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_cmd)
  );

  spc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_pos_i   (max_pos_q),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {{(spc_pkg::OutDataW - ResW){1'b0}}, res};

endmodule

### src/spc_checker.sv
// port checker for the stepper position controller and its bind
module spc_checker #(
  parameter int unsigned QueueDepth = spc_pkg::QueueDepth
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [spc_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned Capacity = QueueDepth + 2;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  logic [CntW-1:0] pend_q, pend_d;
  logic            in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + CntW'(1);
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == '0 |-> !m_axis_tvalid)
    else $error("result without a pending request");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == CapCnt |-> !s_axis_tready)
    else $error("request taken beyond buffer capacity");

  a_stop_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[spc_pkg::PosW+4:spc_pkg::PosW+3] != 2'b11)
    else $error("invalid stop flag");

endmodule

bind stepper_position_controller spc_checker #(
  .QueueDepth (QueueDepth)
) u_spc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### verif/tb_stepper_position_controller.sv
// testbench of the stepper position controller: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_stepper_position_controller;

  localparam int unsigned PosW     = spc_pkg::PosW;
  localparam int unsigned MaxW     = spc_pkg::MaxW;
  localparam int unsigned OpW      = spc_pkg::OpW;
  localparam int unsigned InDataW  = spc_pkg::InDataW;
  localparam int unsigned OutDataW = spc_pkg::OutDataW;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned LongHold      = 200;
  localparam int unsigned LongHoldAfter = 150;
  localparam int unsigned PhaseItems    = 55;

  localparam int unsigned LimitsBit  = PosW;
  localparam int unsigned EndstopBit = PosW + 1;
  localparam int unsigned CancelBit  = PosW + 2;
  localparam int unsigned ResultW    = $bits(spc_pkg::result_t);

  localparam logic [OpW-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_LAST  = 3'd7;

  typedef enum logic [1:0] {
    HOME_NONE,
    HOME_LOW,
    HOME_HIGH
  } home_e;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_HALF,
    READY_PERIODIC
  } ready_style_e;

  class stepper_scoreboard;
    logic [MaxW-1:0]        max_pos;
    logic signed [PosW-1:0] pos;
    longint                 steps_left;
    logic [1:0]             phase;
    spc_pkg::stop_e         flag;
    home_e                  homing;
    spc_pkg::result_t       result_q[$];
    int                     errors;

    function new();
      max_pos    = spc_pkg::MaxReset;
      pos        = '0;
      steps_left = 0;
      phase      = '0;
      flag       = spc_pkg::STOP_OK;
      homing     = HOME_NONE;
      errors     = 0;
    endfunction

    function void start_move(longint target, logic limits);
      if (limits) begin
        if (target > longint'(max_pos)) target = longint'(max_pos);
        if (target < 0) target = 0;
      end
      steps_left = target - longint'(pos);
      flag       = spc_pkg::STOP_OK;
      homing     = HOME_NONE;
    endfunction

    function void take_step(logic endstop, logic cancel);
      if (steps_left == 0) return;
      if (endstop) begin
        flag       = spc_pkg::STOP_ENDSTOP;
        steps_left = 0;
        if (homing == HOME_LOW) pos = '0;
        else if (homing == HOME_HIGH) pos = {1'b0, max_pos};
        homing = HOME_NONE;
      end else if (cancel) begin
        flag       = spc_pkg::STOP_CANCEL;
        steps_left = 0;
        homing     = HOME_NONE;
      end else begin
        if (steps_left > 0) begin
          phase = phase + 2'd1;
          pos   = pos + PosW'(1);
          steps_left--;
        end else begin
          phase = phase - 2'd1;
          pos   = pos - PosW'(1);
          steps_left++;
        end
        if (steps_left == 0) homing = HOME_NONE;
      end
    endfunction

    function void note_request(logic [OpW-1:0] op, logic [InDataW-1:0] data);
      logic signed [PosW-1:0] distance;
      spc_pkg::result_t       r;
      distance = data[PosW-1:0];
      case (op)
        spc_pkg::OP_TICK:     take_step(data[EndstopBit], data[CancelBit]);
        spc_pkg::OP_MOVE_REL: start_move(longint'(pos) + longint'(distance), data[LimitsBit]);
        spc_pkg::OP_MOVE_ABS: start_move(longint'(distance), data[LimitsBit]);
        spc_pkg::OP_HOME_LOW: begin
          steps_left = -longint'(max_pos);
          flag       = spc_pkg::STOP_OK;
          homing     = (steps_left != 0) ? HOME_LOW : HOME_NONE;
        end
        spc_pkg::OP_HOME_HIGH: begin
          steps_left = longint'(max_pos);
          flag       = spc_pkg::STOP_OK;
          homing     = (steps_left != 0) ? HOME_HIGH : HOME_NONE;
        end
        default: ;
      endcase
      r.coil_a   = phase[1] ^ phase[0];
      r.coil_b   = phase[1];
      r.position = pos;
      r.busy     = (steps_left != 0);
      r.stop     = flag;
      result_q.push_back(r);
    endfunction

    function void report(string field, longint expected, longint actual);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      spc_pkg::result_t exp_r;
      spc_pkg::result_t got;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %h", $time, data);
        return;
      end
      exp_r = result_q.pop_front();
      got   = data[ResultW-1:0];
      if (got.coil_a !== exp_r.coil_a) report("coil_a", exp_r.coil_a, got.coil_a);
      if (got.coil_b !== exp_r.coil_b) report("coil_b", exp_r.coil_b, got.coil_b);
      if (got.position !== exp_r.position)
        report("position", longint'($signed(exp_r.position)), longint'($signed(got.position)));
      if (got.busy !== exp_r.busy) report("busy", exp_r.busy, got.busy);
      if (got.stop !== exp_r.stop) report("stop_flag", exp_r.stop, got.stop);
      if (data[OutDataW-1:ResultW] !== '0) report("padding", 0, data[OutDataW-1:ResultW]);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [MaxW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // distance, use_limits, endstop, cancel
  logic [OpW-1:0]      s_axis_tuser;   // op
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // coil_a, coil_b, position, busy_res, stop_flag

  stepper_scoreboard sb;
  int unsigned       requests_sent;
  int unsigned       burst_left;
  int unsigned       idle_cycles = 0;

  stepper_position_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  task automatic send_request(logic [OpW-1:0] op, logic [PosW-1:0] distance, logic limits,
                              logic endstop, logic cancel);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(InDataW - PosW - 3){1'b0}}, cancel, endstop, limits, distance};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  task automatic write_max(logic [MaxW-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sb.max_pos = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    ready_style_e style;
    int unsigned  style_left;
    int unsigned  hold_left;
    bit           held_long;
    m_axis_tready = 1'b0;
    style         = READY_ALWAYS;
    style_left    = 0;
    hold_left     = 0;
    held_long     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held_long && requests_sent >= LongHoldAfter) begin
        held_long = 1'b1;
        hold_left = LongHold;
      end
      if (style_left == 0) begin
        style      = ready_style_e'($urandom_range(READY_ALWAYS, READY_PERIODIC));
        style_left = $urandom_range(8, 64);
      end
      style_left--;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (style)
          READY_ALWAYS:  m_axis_tready <= 1'b1;
          READY_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
          READY_HALF:    m_axis_tready <= 1'($urandom_range(0, 1));
          default:       m_axis_tready <= (style_left % 5 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [MaxW-1:0]  max_list [7];
    logic [OpW-1:0]   op;
    longint           target;
    int unsigned      phase_items;
    int unsigned      n_ticks;
    sb            = new();
    requests_sent = 0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = spc_pkg::OP_TICK;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // idle tick ignores endstop and cancel, spare ops report state
    send_request(spc_pkg::OP_TICK, '0, 1'b1, 1'b1, 1'b1);
    for (int o = OP_SPARE_FIRST; o <= OP_SPARE_LAST; o++)
      send_request(OpW'(o), {PosW{1'b1}}, 1'b1, 1'b1, 1'b1);
    send_request(spc_pkg::OP_MOVE_REL, PosW'(3), 1'b0, 1'b0, 1'b0);
    repeat (3) send_request(spc_pkg::OP_TICK, '0, 1'b0, 1'b0, 1'b0);
    // clamped below zero, then endstop wins over cancel
    send_request(spc_pkg::OP_MOVE_REL, -PosW'(5), 1'b1, 1'b0, 1'b0);
    send_request(spc_pkg::OP_TICK, '0, 1'b0, 1'b0, 1'b0);
    send_request(spc_pkg::OP_TICK, '0, 1'b0, 1'b1, 1'b1);
    send_request(spc_pkg::OP_MOVE_ABS, -PosW'(2), 1'b0, 1'b0, 1'b0);
    send_request(spc_pkg::OP_TICK, '0, 1'b0, 1'b0, 1'b0);
    send_request(spc_pkg::OP_TICK, '0, 1'b0, 1'b0, 1'b1);
    // homing high lands on max, then wrap past the positive limit
    send_request(spc_pkg::OP_HOME_HIGH, '0, 1'b0, 1'b0, 1'b0);
    send_request(spc_pkg::OP_TICK, '0, 1'b0, 1'b1, 1'b0);
    send_request(spc_pkg::OP_MOVE_REL, PosW'(2), 1'b0, 1'b0, 1'b0);
    repeat (2) send_request(spc_pkg::OP_TICK, '0, 1'b0, 1'b0, 1'b0);
    send_request(spc_pkg::OP_HOME_LOW, '0, 1'b0, 1'b0, 1'b0);
    send_request(spc_pkg::OP_TICK, '0, 1'b0, 1'b1, 1'b0);
    send_request(spc_pkg::OP_MOVE_ABS, {1'b0, {(PosW - 1){1'b1}}}, 1'b1, 1'b0, 1'b0);
    send_request(spc_pkg::OP_MOVE_ABS, {1'b1, {(PosW - 1){1'b0}}}, 1'b0, 1'b0, 1'b0);
    send_request(spc_pkg::OP_TICK, '0, 1'b0, 1'b0, 1'b1);

    max_list = '{spc_pkg::MaxReset, '0, MaxW'(1), MaxW'(7), MaxW'(40),
                 MaxW'($urandom_range(2, 1000)), MaxW'($urandom())};
    foreach (max_list[i]) begin
      write_max(max_list[i]);
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          op = ($urandom_range(0, 1) == 0) ? spc_pkg::OP_TICK
                                            : OpW'($urandom_range(OP_SPARE_FIRST,
                                                                  OP_SPARE_LAST));
          send_request(op, PosW'($urandom()), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          op = OpW'($urandom_range(spc_pkg::OP_MOVE_REL, spc_pkg::OP_HOME_HIGH));
          case ($urandom_range(0, 2))
            0:       target = 0;
            1:       target = longint'(sb.pos);
            default: target = longint'(sb.max_pos);
          endcase
          target = target + longint'($urandom_range(0, 40)) - 20;
          if (op == spc_pkg::OP_MOVE_REL) target = longint'($urandom_range(0, 40)) - 20;
          if ($urandom_range(0, 7) == 0) target = longint'($urandom());
          send_request(op, target[PosW-1:0], 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          phase_items++;
          n_ticks = $urandom_range(0, 24);
          repeat (n_ticks) begin
            send_request(spc_pkg::OP_TICK, PosW'($urandom()), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0);
            phase_items++;
          end
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
src/spc_pkg.sv
src/spc_front.sv
src/spc_queue.sv
src/spc_back.sv
src/stepper_position_controller.sv
src/spc_checker.sv
verif/tb_stepper_position_controller.sv
